// ===== rtl/lpfd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Shared widths, register indexes, reset values and result codes.
// ---------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HEADER_W   = 32;
  localparam int unsigned TAIL_W     = 16;
  localparam int unsigned LENGTH_W   = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PATTERN   = 1'd1;

  // Register reset values.
  localparam logic [HEADER_W-1:0] HEADER_PATTERN_RST = 32'h0FF0_00FF;
  localparam logic [TAIL_W-1:0]   TAIL_PATTERN_RST   = 16'h0D0A;

  // Result word codes.
  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

endpackage

// ===== rtl/lpfd_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for received bytes and for deframed result words.
// ---------------------------------------------------------------------------
interface lpfd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [lpfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_frame_if;
  logic                          valid;
  logic                          ready;
  logic [lpfd_pkg::KIND_W-1:0]   out_kind;
  logic [lpfd_pkg::BYTE_W-1:0]   payload_byte;
  logic [lpfd_pkg::BYTE_W-1:0]   frame_kind;
  logic [lpfd_pkg::LENGTH_W-1:0] payload_length;
  logic                          last_payload;

  modport source (output valid, output out_kind, output payload_byte, output frame_kind,
                  output payload_length, output last_payload, input ready);
  modport sink   (input valid, input out_kind, input payload_byte, input frame_kind,
                  input payload_length, input last_payload, output ready);
endinterface

// ===== rtl/length_prefixed_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed frame deframer
// Finds frames in a byte stream and emits payload words and end markers.
// ---------------------------------------------------------------------------
// byte_in takes one received word per cycle while ready is high. The block
// slides a four-byte window over the stream until it matches header_pattern,
// then reads a big-endian 16-bit length and a type byte, forwards each
// payload byte on frame_out tagged with type and length, and finally checks
// the two tail bytes against tail_pattern, emitting one good or bad end
// marker. Header, length, type and first tail bytes produce no output word.
//
// Each accepted byte is parsed in the cycle it arrives; its result word, if
// any, shows on frame_out in the next cycle from the output register. A byte
// can be accepted every cycle unless frame_out stalls: byte_in.ready is low
// only while the output register holds a word that the receiver has not yet
// taken, so a stall holds the input back after exactly one word of buffering.
//
// Reset (rst, synchronous) returns the parser to header hunting with an
// empty window, clears the output register and reloads both patterns with
// their default values. Configuration writes through cfg_we take effect at
// once and are meant to happen only while the block is idle.
// ---------------------------------------------------------------------------
module length_prefixed_frame_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  lpfd_byte_if.sink                      byte_in,
  lpfd_frame_if.source                   frame_out
);
  import lpfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENHI,
    PH_LENLO,
    PH_TYPE,
    PH_DATA,
    PH_TAIL1,
    PH_TAIL2
  } phase_t;

  // Configuration registers.
  logic [HEADER_W-1:0] header_pattern;
  logic [TAIL_W-1:0]   tail_pattern;

  // Parser state.
  phase_t              phase, phase_next;
  logic [HEADER_W-1:0] header_window, header_window_next;
  logic [2:0]          hunt_fill, hunt_fill_next;
  logic [LENGTH_W-1:0] length_reg, length_reg_next;
  logic [LENGTH_W-1:0] remaining_count, remaining_count_next;
  logic [BYTE_W-1:0]   type_reg, type_reg_next;
  logic [BYTE_W-1:0]   first_tail_byte, first_tail_byte_next;

  // Output register.
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_byte;
  logic [BYTE_W-1:0]   out_frame_kind;
  logic [LENGTH_W-1:0] out_length;
  logic                out_last;

  // Result of the byte being parsed this cycle.
  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [BYTE_W-1:0]   emit_byte;
  logic                emit_last;

  logic                accept;
  logic [BYTE_W-1:0]   b;

  assign byte_in.ready = !out_valid || frame_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign b             = byte_in.rx_byte;

  always_comb begin
    phase_next           = phase;
    header_window_next   = header_window;
    hunt_fill_next       = hunt_fill;
    length_reg_next      = length_reg;
    remaining_count_next = remaining_count;
    type_reg_next        = type_reg;
    first_tail_byte_next = first_tail_byte;
    emit                 = 1'b0;
    emit_kind            = KIND_PAYLOAD;
    emit_byte            = '0;
    emit_last            = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        header_window_next = {header_window[HEADER_W-BYTE_W-1:0], b};
        if (hunt_fill != 3'd4) begin
          hunt_fill_next = hunt_fill + 3'd1;
        end
        // The window only counts once four fresh bytes are in it.
        if (hunt_fill_next == 3'd4 && header_window_next == header_pattern) begin
          phase_next = PH_LENHI;
        end
      end
      PH_LENHI: begin
        length_reg_next = {b, {BYTE_W{1'b0}}};
        phase_next      = PH_LENLO;
      end
      PH_LENLO: begin
        length_reg_next      = {length_reg[LENGTH_W-1:BYTE_W], b};
        remaining_count_next = {length_reg[LENGTH_W-1:BYTE_W], b};
        phase_next           = PH_TYPE;
      end
      PH_TYPE: begin
        type_reg_next = b;
        // A zero-length frame skips straight to the tail.
        phase_next    = (remaining_count == '0) ? PH_TAIL1 : PH_DATA;
      end
      PH_DATA: begin
        emit_last            = (remaining_count <= LENGTH_W'(1));
        remaining_count_next = remaining_count - LENGTH_W'(1);
        emit                 = 1'b1;
        emit_kind            = KIND_PAYLOAD;
        emit_byte            = b;
        if (emit_last) begin
          phase_next = PH_TAIL1;
        end
      end
      PH_TAIL1: begin
        first_tail_byte_next = b;
        phase_next           = PH_TAIL2;
      end
      PH_TAIL2: begin
        emit               = 1'b1;
        emit_kind          = ({first_tail_byte, b} == tail_pattern) ? KIND_END_GOOD
                                                                     : KIND_END_BAD;
        phase_next         = PH_HUNT;
        header_window_next = '0;
        hunt_fill_next     = '0;
      end
      default: begin
        phase_next         = PH_HUNT;
        header_window_next = '0;
        hunt_fill_next     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern  <= HEADER_PATTERN_RST;
      tail_pattern    <= TAIL_PATTERN_RST;
      phase           <= PH_HUNT;
      header_window   <= '0;
      hunt_fill       <= '0;
      length_reg      <= '0;
      remaining_count <= '0;
      type_reg        <= '0;
      first_tail_byte <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEADER_PATTERN: header_pattern <= cfg_data[HEADER_W-1:0];
          CFG_TAIL_PATTERN:   tail_pattern   <= cfg_data[TAIL_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        phase           <= phase_next;
        header_window   <= header_window_next;
        hunt_fill       <= hunt_fill_next;
        length_reg      <= length_reg_next;
        remaining_count <= remaining_count_next;
        type_reg        <= type_reg_next;
        first_tail_byte <= first_tail_byte_next;
      end

      // The output register frees when taken and refills from the byte
      // accepted in the same cycle.
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
    end

    if (accept && emit) begin
      out_kind       <= emit_kind;
      out_byte       <= emit_byte;
      out_frame_kind <= type_reg;
      out_length     <= length_reg;
      out_last       <= emit_last;
    end
  end

  assign frame_out.valid          = out_valid;
  assign frame_out.out_kind       = out_kind;
  assign frame_out.payload_byte   = out_byte;
  assign frame_out.frame_kind     = out_frame_kind;
  assign frame_out.payload_length = out_length;
  assign frame_out.last_payload   = out_last;

endmodule
